// ===== design/uer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranging block
// phase and status codes, counter widths, scale factor and config layout
// ----------------------------------------------------------------------------
package uer_pkg;

  // tick counters
  localparam int unsigned CountBits = 20;
  localparam logic [CountBits-1:0] CountMax = '1;

  // register and field widths
  localparam int unsigned TimeoutW = 20;
  localparam int unsigned MaxDistW = 10;
  localparam int unsigned DistW    = 17;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned LimExtW  = (CountBits > TimeoutW) ? CountBits : TimeoutW;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = TimeoutW;
  localparam logic [CfgIdxW-1:0] CfgTimeout = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxDist = 1'b1;

  localparam logic [TimeoutW-1:0] TimeoutRst = TimeoutW'(30000);
  localparam logic [MaxDistW-1:0] MaxDistRst = MaxDistW'(400);

  // request function codes
  localparam logic FuncStart = 1'b0;
  localparam logic FuncTick  = 1'b1;

  // trigger pulse shape in ticks
  localparam int unsigned TrigLowTicks  = 2;
  localparam int unsigned TrigHighTicks = 10;

  // half the round-trip sound speed: 0.01715 cm/us, i.e. 1715/1000 hundredths per us
  localparam int unsigned ScaleNum   = 1715;
  localparam int unsigned ScaleDen   = 1000;
  localparam int unsigned ScaleWhole = ScaleNum / ScaleDen;
  localparam int unsigned ScaleFrac  = ScaleNum % ScaleDen;
  localparam int unsigned RemW       = $clog2(ScaleDen);
  localparam int unsigned HundredthsPerCm = 100;

  // running distance; ScaleWhole + 1 is at most 2, so one extra bit covers it
  localparam int unsigned AccW   = CountBits + 1;
  localparam int unsigned BoundW = 17;
  localparam int unsigned CmpW   = (AccW > BoundW) ? AccW : BoundW;

  typedef enum logic [PhaseW-1:0] {
    PhIdle     = 3'd0,
    PhTrigLow  = 3'd1,
    PhTrigHigh = 3'd2,
    PhWait     = 3'd3,
    PhMeasure  = 3'd4
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    StNone    = 3'd0,
    StOk      = 3'd1,
    StNoEcho  = 3'd2,
    StTooLong = 3'd3,
    StRange   = 3'd4
  } status_e;

  typedef struct packed {
    logic [CountBits-1:0] lim;
    logic [MaxDistW-1:0]  max_dist;
  } cfg_t;

  typedef struct packed {
    logic                trigger;
    logic                busy;
    status_e             status;
    logic [DistW-1:0]    distance;
  } res_t;

endpackage

// ===== design/uer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_core: ranging sequencer
// trigger pulse, echo wait, echo width count with running distance, result
// ----------------------------------------------------------------------------
module uer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          func_i,
  input  logic          echo_i,
  input  uer_pkg::cfg_t cfg_i,
  output uer_pkg::res_t res_o
);
  import uer_pkg::*;

  phase_e               phase_q, phase_d;
  logic [CountBits-1:0] ticks_q, ticks_d;
  logic [CountBits-1:0] width_q, width_d;
  logic [AccW-1:0]      acc_q, acc_d;
  logic [RemW-1:0]      rem_q, rem_d;

  logic [CountBits-1:0] ticks_inc;
  logic [CountBits-1:0] ticks_sat;
  logic [RemW:0]        rem_sum;
  logic                 carry;
  logic [RemW-1:0]      rem_next;
  logic [AccW-1:0]      acc_next;
  logic [BoundW-1:0]    bound;
  logic [CmpW-1:0]      acc_ext;
  logic                 over;
  status_e              status;
  logic [DistW-1:0]     distance;

  assign ticks_inc = ticks_q + 1'b1;
  assign ticks_sat = (ticks_q != CountMax) ? ticks_inc : ticks_q;

  // distance tracks width * 1715 / 1000 as whole part plus remainder
  assign rem_sum  = {1'b0, rem_q} + (RemW+1)'(ScaleFrac);
  assign carry    = (rem_sum >= (RemW+1)'(ScaleDen));
  assign rem_next = carry ? RemW'(rem_sum - (RemW+1)'(ScaleDen)) : rem_sum[RemW-1:0];
  assign acc_next = acc_q + AccW'(ScaleWhole) + AccW'(carry);

  // width*1715 >= max*100000 is the same as floor(width*1715/1000) >= max*100
  assign bound   = BoundW'(cfg_i.max_dist) * BoundW'(HundredthsPerCm);
  assign acc_ext = CmpW'(acc_q);
  assign over    = (acc_ext >= CmpW'(bound));

  always_comb begin
    phase_d  = phase_q;
    ticks_d  = ticks_q;
    width_d  = width_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    status   = StNone;
    distance = '0;

    if (step_i) begin
      if (func_i == FuncStart) begin
        if (phase_q == PhIdle) begin
          phase_d = PhTrigLow;
          ticks_d = '0;
          width_d = '0;
          acc_d   = '0;
          rem_d   = '0;
        end
      end else begin
        unique case (phase_q)
          PhIdle: begin
          end
          PhTrigLow: begin
            ticks_d = ticks_inc;
            if (ticks_inc >= CountBits'(TrigLowTicks)) begin
              phase_d = PhTrigHigh;
              ticks_d = '0;
            end
          end
          PhTrigHigh: begin
            ticks_d = ticks_inc;
            if (ticks_inc >= CountBits'(TrigHighTicks)) begin
              phase_d = PhWait;
              ticks_d = '0;
            end
          end
          PhWait: begin
            if (echo_i) begin
              if (cfg_i.lim == '0) begin
                status  = StTooLong;
                phase_d = PhIdle;
              end else begin
                // rising tick counts as width one
                width_d = CountBits'(1);
                acc_d   = AccW'(ScaleWhole);
                rem_d   = RemW'(ScaleFrac);
                phase_d = PhMeasure;
              end
            end else begin
              ticks_d = ticks_sat;
              if (ticks_sat >= cfg_i.lim) begin
                status  = StNoEcho;
                phase_d = PhIdle;
              end
            end
          end
          PhMeasure: begin
            if (echo_i) begin
              if (width_q >= cfg_i.lim) begin
                status  = StTooLong;
                phase_d = PhIdle;
              end else begin
                width_d = width_q + 1'b1;
                acc_d   = acc_next;
                rem_d   = rem_next;
              end
            end else begin
              if ((width_q == '0) || over) begin
                status = StRange;
              end else begin
                status   = StOk;
                distance = acc_ext[DistW-1:0];
              end
              phase_d = PhIdle;
            end
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
        if (phase_d == PhIdle) begin
          ticks_d = '0;
          width_d = '0;
          acc_d   = '0;
          rem_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      ticks_q <= '0;
      width_q <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      width_q <= width_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
    end
  end

  assign res_o.trigger  = (phase_d == PhTrigHigh);
  assign res_o.busy     = (phase_d != PhIdle);
  assign res_o.status   = status;
  assign res_o.distance = distance;

endmodule

// ===== design/ultrasonic_echo_ranging_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranging_top: ultrasonic ranging controller
// start and microsecond-tick requests drive a trigger pulse, echo timing and
// a distance in hundredths of a cm with a status code per request
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  in        input      in_valid_i/in_ready_o   func_i, echo_i
//  out       output     out_valid_o/out_ready_i trigger_o, busy_res_o, status_o,
//                                               distance_hundredths_cm_o
//  cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one request per cycle while out is not stalled; each result appears in the cycle after its request is
// taken, from a single result register fed by the sequencer's next-state logic
// reset clears the config registers to their defaults and the sequencer to idle
// while a result waits, a new request is still taken in the cycle the result
// is taken; only when out is stalled with a result held does in_ready_o drop
// cfg writes are always taken, as cfg_ready_o is tied high
//
module ultrasonic_echo_ranging_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // requests
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic                            echo_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            trigger_o,
  output logic                            busy_res_o,
  output logic [uer_pkg::StatusW-1:0]     status_o,
  output logic [uer_pkg::DistW-1:0]       distance_hundredths_cm_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [uer_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [uer_pkg::CfgDataW-1:0]    cfg_data_i
);
  import uer_pkg::*;

  logic [TimeoutW-1:0] timeout_q;
  logic [MaxDistW-1:0] max_dist_q;
  logic                out_valid_q, out_valid_d;
  res_t                res_q;
  res_t                res_d;
  cfg_t                cfg;
  logic                accept;
  logic [LimExtW-1:0]  timeout_ext;

  // config writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= TimeoutRst;
      max_dist_q <= MaxDistRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgTimeout: timeout_q  <= cfg_data_i[TimeoutW-1:0];
        CfgMaxDist: max_dist_q <= cfg_data_i[MaxDistW-1:0];
        default: begin
        end
      endcase
    end
  end

  // timeout capped at the tick counter's top value
  assign timeout_ext  = LimExtW'(timeout_q);
  assign cfg.lim      = (timeout_ext > LimExtW'(CountMax)) ? CountMax
                                                            : timeout_ext[CountBits-1:0];
  assign cfg.max_dist = max_dist_q;

  // handshake: the result register frees up in the cycle it is taken
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  uer_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .func_i (func_i),
    .echo_i (echo_i),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only with an accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign trigger_o                = res_q.trigger;
  assign busy_res_o               = res_q.busy;
  assign status_o                 = res_q.status;
  assign distance_hundredths_cm_o = res_q.distance;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ultrasonic echo ranging controller
// drives start and tick requests through a short directed table and then
// random measurement sequences under several timeout and range settings,
// predicts every result in a local ranging model and compares each result
// field by field, in order, with random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb;
  import uer_pkg::*;

  localparam int unsigned Phases        = 8;
  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned SettleCycles  = 4;   // result register latency plus margin
  localparam int unsigned DrainLimit    = 10000;
  localparam int unsigned MaxSpan       = 300; // longest echo wait or width we ask for
  localparam int unsigned ShowErrors    = 10;

  // directed stimulus: each row is one request, repeated reps times
  typedef struct packed {
    logic       func;
    logic       echo;
    logic [3:0] reps;
    logic       typed;  // res holds the expected result, else predicted
    res_t       res;
  } dir_row_t;

  localparam int unsigned DirRows = 8;
  localparam dir_row_t DirTab [DirRows] = '{
    // tick while idle, state straight out of reset
    '{FuncTick,  1'b1, 4'd1,  1'b1, '{1'b0, 1'b0, StNone, '0}},
    // start begins trigger low
    '{FuncStart, 1'b0, 4'd1,  1'b1, '{1'b0, 1'b1, StNone, '0}},
    // start while busy is ignored
    '{FuncStart, 1'b1, 4'd1,  1'b1, '{1'b0, 1'b1, StNone, '0}},
    // echo high during the trigger pulse is ignored
    '{FuncTick,  1'b1, 4'd2,  1'b0, '0},
    '{FuncTick,  1'b1, 4'd10, 1'b0, '0},
    // one tick waiting, then echo rises and falls after a single tick
    '{FuncTick,  1'b0, 4'd1,  1'b0, '0},
    '{FuncTick,  1'b1, 4'd1,  1'b0, '0},
    '{FuncTick,  1'b0, 4'd1,  1'b1, '{1'b0, 1'b0, StOk, DistW'(1)}}
  };

  typedef enum logic [1:0] {
    SinkOpen,
    SinkPattern,
    SinkBusy,
    SinkSlow
  } sink_mode_e;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request channel
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic func_i     = FuncTick;
  logic echo_i     = 1'b0;

  // result channel
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                trigger_o;
  logic                busy_res_o;
  logic [StatusW-1:0]  status_o;
  logic [DistW-1:0]    distance_hundredths_cm_o;

  // register writes
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgTimeout;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // ranging model state and its copy of the registers
  phase_e               rng_phase;
  logic [CountBits-1:0] rng_ticks;
  logic [CountBits-1:0] rng_width;
  logic [TimeoutW-1:0]  reg_timeout;
  logic [MaxDistW-1:0]  reg_max_cm;

  // expected readings, oldest first
  res_t readings_q [$];

  int unsigned n_fail     = 0;
  int unsigned n_live     = 0;  // requests that the block acts on
  int unsigned burst_left = 0;
  int unsigned gap_max    = 0;

  sink_mode_e  sink_mode = SinkOpen;
  logic [31:0] sink_pat  = '1;
  logic [7:0]  sink_cnt  = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  ultrasonic_echo_ranging_top i_dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .func_i                   (func_i),
    .echo_i                   (echo_i),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .trigger_o                (trigger_o),
    .busy_res_o               (busy_res_o),
    .status_o                 (status_o),
    .distance_hundredths_cm_o (distance_hundredths_cm_o),
    .cfg_valid_i              (cfg_valid_i),
    .cfg_ready_o              (cfg_ready_o),
    .cfg_index_i              (cfg_index_i),
    .cfg_data_i               (cfg_data_i)
  );

  function automatic void flag_error(input string msg);
    if (n_fail < ShowErrors) $display("%s", msg);
    n_fail++;
  endfunction

  // one step of the ranging sequencer for an accepted request
  task automatic ranging_step(input logic func, input logic echo, output res_t res);
    logic [LimExtW-1:0] lim;
    logic [63:0]        scaled;
    logic [63:0]        bound;
    status_e            st;
    logic [DistW-1:0]   distance;
    lim  = (LimExtW'(reg_timeout) > LimExtW'(CountMax)) ? LimExtW'(CountMax)
                                                         : LimExtW'(reg_timeout);
    st       = StNone;
    distance = '0;
    if (func == FuncStart) begin
      if (rng_phase == PhIdle) begin
        rng_phase = PhTrigLow;
        rng_ticks = '0;
        rng_width = '0;
      end
    end else begin
      case (rng_phase)
        PhTrigLow: begin
          rng_ticks++;
          if (rng_ticks >= TrigLowTicks) begin
            rng_phase = PhTrigHigh;
            rng_ticks = '0;
          end
        end
        PhTrigHigh: begin
          rng_ticks++;
          if (rng_ticks >= TrigHighTicks) begin
            rng_phase = PhWait;
            rng_ticks = '0;
          end
        end
        PhWait: begin
          if (echo) begin
            // a zero limit fails on the rising tick itself
            if (lim == '0) begin
              st        = StTooLong;
              rng_phase = PhIdle;
            end else begin
              rng_width = CountBits'(1);
              rng_phase = PhMeasure;
            end
          end else begin
            if (rng_ticks != CountMax) rng_ticks++;
            if (rng_ticks >= lim) begin
              st        = StNoEcho;
              rng_phase = PhIdle;
            end
          end
        end
        PhMeasure: begin
          if (echo) begin
            if (rng_width >= lim) begin
              st        = StTooLong;
              rng_phase = PhIdle;
            end else begin
              rng_width++;
            end
          end else begin
            scaled = 64'(rng_width) * 64'(ScaleNum);
            bound  = 64'(reg_max_cm) * 64'(HundredthsPerCm) * 64'(ScaleDen);
            if (rng_width == '0 || scaled >= bound) begin
              st = StRange;
            end else begin
              st       = StOk;
              distance = DistW'(scaled / 64'(ScaleDen));
            end
            rng_phase = PhIdle;
          end
        end
        default: rng_phase = PhIdle;
      endcase
      if (rng_phase == PhIdle) begin
        rng_ticks = '0;
        rng_width = '0;
      end
    end
    res.trigger  = (rng_phase == PhTrigHigh);
    res.busy     = (rng_phase != PhIdle);
    res.status   = st;
    res.distance = distance;
  endtask

  // hold requests off until every expected reading has come back
  task automatic drain_readings(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (readings_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // send one request in the current burst, return its predicted reading
  task automatic send_req(input logic func, input logic echo, output res_t res);
    int unsigned gap;
    // now and then let the result side run dry mid-sequence
    if (readings_q.size() != 0 && $urandom_range(0, 99) == 0) drain_readings(0);
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    echo_i     <= echo;
    do @(posedge clk_i); while (!in_ready_o);
    // idle ticks and starts while busy leave the block as it was
    if (!((func == FuncTick && rng_phase == PhIdle) ||
          (func == FuncStart && rng_phase != PhIdle))) n_live++;
    ranging_step(func, echo, res);
    burst_left--;
  endtask

  task automatic send_tick(input logic echo);
    res_t res;
    // occasional start while a measurement runs, which must be ignored
    if (rng_phase != PhIdle && $urandom_range(0, 19) == 0) begin
      send_req(FuncStart, 1'($urandom), res);
      readings_q.push_back(res);
    end
    send_req(FuncTick, echo, res);
    readings_q.push_back(res);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    drain_readings(SettleCycles);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgTimeout) reg_timeout = data[TimeoutW-1:0];
    else                   reg_max_cm  = data[MaxDistW-1:0];
  endtask

  // length of an echo wait or an echo pulse: mostly short, sometimes up to
  // just past the limit so that timeouts and range failures show up
  function automatic int unsigned pick_span();
    int unsigned top;
    top = (reg_timeout >= MaxSpan) ? MaxSpan : int'(reg_timeout) + 1;
    if ($urandom_range(0, 1) == 1) return $urandom_range(0, 5);
    return $urandom_range(0, top);
  endfunction

  // one well-formed measurement with random content
  task automatic run_measurement();
    res_t        res;
    int unsigned span;
    send_req(FuncStart, 1'($urandom), res);
    readings_q.push_back(res);
    while (rng_phase inside {PhTrigLow, PhTrigHigh}) send_tick(1'($urandom));
    span = pick_span();
    repeat (span) if (rng_phase == PhWait) send_tick(1'b0);
    if (rng_phase == PhWait) send_tick(1'b1);
    span = pick_span();
    repeat (span) if (rng_phase == PhMeasure) send_tick(1'b1);
    if (rng_phase == PhMeasure) send_tick(1'b0);
  endtask

  // receiver: switches between stall patterns each time the 8-bit sink counter wraps
  always @(posedge clk_i) begin
    if (sink_cnt == '0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_pat  = $urandom | 32'h1;
    end
    sink_cnt++;
    case (sink_mode)
      SinkOpen:    out_ready_i <= 1'b1;
      SinkPattern: out_ready_i <= sink_pat[sink_cnt[4:0]];
      SinkBusy:    out_ready_i <= ($urandom_range(0, 99) < 75);
      default:     out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // result checker: every taken result against the oldest expected reading
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.trigger  = trigger_o;
      got.busy     = busy_res_o;
      got.status   = status_e'(status_o);
      got.distance = distance_hundredths_cm_o;
      if (readings_q.size() == 0) begin
        flag_error($sformatf("unexpected result: trig=%0b busy=%0b st=%0d dist=%0d",
                             got.trigger, got.busy, got.status, got.distance));
      end else begin
        want = readings_q.pop_front();
        if (got.trigger !== want.trigger || got.busy !== want.busy ||
            got.status !== want.status || got.distance !== want.distance) begin
          flag_error($sformatf({"mismatch: exp trig=%0b busy=%0b st=%0d dist=%0d",
                                " got trig=%0b busy=%0b st=%0d dist=%0d"},
                               want.trigger, want.busy, want.status, want.distance,
                               got.trigger, got.busy, got.status, got.distance));
        end
      end
    end
  end

  initial begin
    res_t                res;
    int unsigned         base;
    logic [TimeoutW-1:0] tmo;
    logic [MaxDistW-1:0] max_cm;
    logic [CfgDataW-1:0] data;

    reg_timeout = TimeoutRst;
    reg_max_cm  = MaxDistRst;
    rng_phase   = PhIdle;
    rng_ticks   = '0;
    rng_width   = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset settings
    gap_max = 2;
    for (int i = 0; i < DirRows; i++) begin
      repeat (DirTab[i].reps) begin
        send_req(DirTab[i].func, DirTab[i].echo, res);
        readings_q.push_back(DirTab[i].typed ? DirTab[i].res : res);
      end
    end

    // random part, one register setting per phase, extremes included
    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: begin tmo = '0;                  max_cm = MaxDistRst; end
        1: begin tmo = TimeoutW'(1);        max_cm = '0; end
        2: begin tmo = TimeoutW'(2);        max_cm = MaxDistW'(1); end
        3: begin
          tmo    = TimeoutW'($urandom_range(60, 300));
          max_cm = MaxDistW'($urandom_range(1, 4));
        end
        4: begin
          tmo    = TimeoutW'($urandom_range(3, 120));
          max_cm = MaxDistW'($urandom);
        end
        5: begin tmo = '1;                  max_cm = '1; end
        6: begin tmo = TimeoutW'(1000000);  max_cm = MaxDistW'(1000); end
        default: begin tmo = TimeoutRst;    max_cm = MaxDistRst; end
      endcase
      write_reg(CfgTimeout, tmo);
      // upper data bits are don't-care for the range register
      data                 = CfgDataW'($urandom);
      data[MaxDistW-1:0]   = max_cm;
      write_reg(CfgMaxDist, data);

      // every third phase sends back to back
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(1, 6);
      base    = n_live;
      while (n_live - base < ItemsPerPhase) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray ticks while idle
          repeat ($urandom_range(1, 3)) begin
            send_req(FuncTick, 1'($urandom), res);
            readings_q.push_back(res);
          end
        end else begin
          run_measurement();
        end
      end
    end

    in_valid_i <= 1'b0;
    for (int i = 0; i < DrainLimit && readings_q.size() != 0; i++) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (readings_q.size() != 0) begin
      flag_error($sformatf("%0d expected results never came", readings_q.size()));
    end

    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
design/uer_pkg.sv
design/uer_core.sv
design/ultrasonic_echo_ranging_top.sv
tb/sv/tb.sv
